FILE: rtl/u2u8_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder: job type, constants and encoding functions.
`default_nettype none
package u2u8_pkg;

    // Number of queue entries between the front and back parts.
    localparam int U2U8_QUEUE_DEPTH = 2;

    // Top six bits of a surrogate code unit.
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // Start of the supplementary planes.
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // Limits between the sequence lengths.
    localparam logic [20:0] LIMIT_ONE   = 21'h80;
    localparam logic [20:0] LIMIT_TWO   = 21'h800;
    localparam logic [20:0] LIMIT_THREE = 21'h10000;

    // One unit of work for the back part: an optional held surrogate to flush
    // as three bytes, then an optional code point to encode.
    typedef struct packed {
        logic        has_flush;
        logic [9:0]  flush_bits;
        logic        has_main;
        logic [20:0] main_cp;
        logic        str_last;
    } t_job;

    // Number of bytes in the UTF-8 form of a code point.
    function automatic logic [2:0] point_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp < LIMIT_ONE) begin
            len = 3'd1;
        end else if (cp < LIMIT_TWO) begin
            len = 3'd2;
        end else if (cp < LIMIT_THREE) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Byte number idx of the UTF-8 form of a code point.
    function automatic logic [7:0] point_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [2:0] len;
        logic [7:0] b;
        len = point_len(cp);
        b   = {2'b10, cp[5:0]};
        case (len)
            3'd1: begin
                b = cp[7:0];
            end
            3'd2: begin
                if (idx == 2'd0) begin
                    b = {3'b110, cp[10:6]};
                end else begin
                    b = {2'b10, cp[5:0]};
                end
            end
            3'd3: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/u2u8_front.sv
// Front part: accepts code units, pairs surrogates and issues jobs to the queue.
`default_nettype none
module u2u8_front
    import u2u8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_string_last,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_job             o_job
);

    logic       r_held_valid;
    logic [9:0] r_held_bits;
    logic       n_held_valid;
    logic [9:0] n_held_bits;
    logic       is_high;
    logic       is_low;
    logic       accept;
    logic       pair;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_high    = (i_code_unit[15:10] == HIGH_SURR_TAG);
    assign is_low     = (i_code_unit[15:10] == LOW_SURR_TAG);
    assign pair       = r_held_valid && is_low;

    // Classify the unit and build the job it causes.
    always_comb begin
        n_held_valid     = r_held_valid;
        n_held_bits      = r_held_bits;
        o_job.str_last   = i_string_last;
        o_job.flush_bits = r_held_bits;
        if (pair) begin
            o_job.has_flush = 1'b0;
            o_job.has_main  = 1'b1;
            o_job.main_cp   = SUPP_BASE + {1'b0, r_held_bits, i_code_unit[9:0]};
            n_held_valid    = 1'b0;
        end else begin
            o_job.has_flush = r_held_valid;
            o_job.has_main  = !(is_high && !i_string_last);
            o_job.main_cp   = {5'd0, i_code_unit};
            n_held_valid    = is_high && !i_string_last;
            n_held_bits     = i_code_unit[9:0];
        end
        o_push = accept && (o_job.has_flush || o_job.has_main);
    end

    // Held surrogate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= 10'd0;
        end else if (accept) begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/u2u8_queue.sv
// Short register queue of jobs between the front and back parts.
`default_nettype none
module u2u8_queue
    import u2u8_pkg::*;
#(
    parameter int DEPTH = U2U8_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Storage is written without reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/u2u8_back.sv
// Back part: expands each job into UTF-8 bytes, one per cycle while the output is not stalled, into an output register.
`default_nettype none
module u2u8_back
    import u2u8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_job        i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_utf8_byte,
    output logic             o_run_last,
    output logic             o_string_end
);

    logic        r_phase_main;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic        r_run_last;
    logic        r_string_end;
    logic        on_flush;
    logic [20:0] cp_sel;
    logic [2:0]  len_sel;
    logic        part_done;
    logic        job_done;
    logic        load;

    // Pick the code point being expanded and see where its bytes end.
    always_comb begin
        on_flush  = i_job.has_flush && !r_phase_main;
        cp_sel    = on_flush ? {5'd0, HIGH_SURR_TAG, i_job.flush_bits} : i_job.main_cp;
        len_sel   = point_len(cp_sel);
        part_done = ({1'b0, r_idx} == (len_sel - 3'd1));
        job_done  = part_done && !(on_flush && i_job.has_main);
        load      = i_q_valid && (!r_out_valid || i_out_ready);
        o_pop     = load && job_done;
    end

    // Byte sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_main <= 1'b0;
            r_idx        <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (job_done) begin
                    r_phase_main <= 1'b0;
                    r_idx        <= 2'd0;
                end else if (part_done) begin
                    r_phase_main <= 1'b1;
                    r_idx        <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte       <= point_byte(cp_sel, r_idx);
            r_run_last   <= job_done;
            r_string_end <= job_done && i_job.str_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_utf8_byte  = r_byte;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_string_end;

endmodule
`default_nettype wire

FILE: rtl/utf16_to_utf8_transcoder_unit.sv
// Top level of the UTF-16 to UTF-8 transcoder.
//
//   Channel  Direction  Handshake                     Payload
//   in       input      i_in_valid / o_in_ready       i_code_unit, i_string_last
//   out      output     o_out_valid / i_out_ready     o_utf8_byte, o_run_last, o_string_end
//
// A code unit is taken whenever the job queue has room; the back part sends one byte
// per cycle while the output is ready, and a unit yields 0 to 6 bytes (typically 1 to 3).
// The output port's one-byte-per-cycle rate sets the throughput.
// Reset is synchronous and active low; it empties the queue and drops a held surrogate.
// Either side may stall: the queue lets the front keep taking units while output waits, until it is full.
`default_nettype none
module utf16_to_utf8_transcoder_unit
    import u2u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = U2U8_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_string_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_utf8_byte,
    output logic             o_run_last,
    output logic             o_string_end
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job push_job;
    t_job head_job;

    // Front part: surrogate pairing.
    u2u8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_code_unit   (i_code_unit),
        .i_string_last (i_string_last),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    // Job queue.
    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Back part: byte generation.
    u2u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (head_job),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_utf8_byte  (o_utf8_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

endmodule
`default_nettype wire

FILE: tb/sv/utf8_stream_checker.sv
// Checker for the UTF-16 to UTF-8 transcoder: predicts the byte stream and compares it.
module utf8_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_string_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_utf8_byte,
    input  logic        i_run_last,
    input  logic        i_string_end,
    output int          o_fail_count,
    output int          o_bytes_pending
);

    // Surrogate ranges and the limits between sequence lengths.
    localparam logic [15:0] HIGH_FIRST    = 16'hD800;
    localparam logic [15:0] HIGH_FINAL    = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST     = 16'hDC00;
    localparam logic [15:0] LOW_FINAL     = 16'hDFFF;
    localparam logic [20:0] SUPP_START    = 21'h10000;
    localparam logic [20:0] ONE_BYTE_TOP  = 21'h80;
    localparam logic [20:0] TWO_BYTE_TOP  = 21'h800;
    localparam logic [7:0]  LEAD_TWO      = 8'hC0;
    localparam logic [7:0]  LEAD_THREE    = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
    localparam logic [7:0]  CONT_TAG      = 8'h80;
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] octet;
        logic       run_last;
        logic       string_end;
    } utf8_out_t;

    utf8_out_t  awaited_bytes[$];
    utf8_out_t  unit_bytes[$];
    logic [9:0] held_bits;
    logic       held_valid;
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    // Adds one byte to the end of the bytes of the current unit.
    task automatic add_unit_byte(input utf8_out_t b);
        unit_bytes.insert(unit_bytes.size(), b);
    endtask

    // Appends the UTF-8 form of one code point to the bytes of the current unit.
    task automatic add_point(input logic [20:0] cp);
        utf8_out_t b;
        b.run_last   = 1'b0;
        b.string_end = 1'b0;
        if (cp < ONE_BYTE_TOP) begin
            b.octet = cp[7:0];
            add_unit_byte(b);
        end else if (cp < TWO_BYTE_TOP) begin
            b.octet = LEAD_TWO | {3'b000, cp[10:6]};
            add_unit_byte(b);
            b.octet = CONT_TAG | {2'b00, cp[5:0]};
            add_unit_byte(b);
        end else if (cp < SUPP_START) begin
            b.octet = LEAD_THREE | {4'b0000, cp[15:12]};
            add_unit_byte(b);
            b.octet = CONT_TAG | {2'b00, cp[11:6]};
            add_unit_byte(b);
            b.octet = CONT_TAG | {2'b00, cp[5:0]};
            add_unit_byte(b);
        end else begin
            b.octet = LEAD_FOUR | {5'b00000, cp[20:18]};
            add_unit_byte(b);
            b.octet = CONT_TAG | {2'b00, cp[17:12]};
            add_unit_byte(b);
            b.octet = CONT_TAG | {2'b00, cp[11:6]};
            add_unit_byte(b);
            b.octet = CONT_TAG | {2'b00, cp[5:0]};
            add_unit_byte(b);
        end
    endtask

    // Works out the bytes that one accepted code unit causes and queues them.
    task automatic predict_unit(input logic [15:0] unit, input logic last);
        logic      is_high;
        logic      is_low;
        utf8_out_t b;
        unit_bytes.delete();
        is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_FINAL);
        is_low  = (unit >= LOW_FIRST) && (unit <= LOW_FINAL);
        if (held_valid && is_low) begin
            add_point(SUPP_START + {1'b0, held_bits, unit[9:0]});
            held_valid = 1'b0;
            held_bits  = '0;
        end else begin
            // A held surrogate that does not pair goes out alone.
            if (held_valid) begin
                add_point({5'b00000, HIGH_FIRST | {6'b000000, held_bits}});
                held_valid = 1'b0;
                held_bits  = '0;
            end
            if (is_high && !last) begin
                held_bits  = unit[9:0];
                held_valid = 1'b1;
            end else begin
                add_point({5'b00000, unit});
            end
        end
        // The final byte of the unit carries the run and string flags.
        if (unit_bytes.size() > 0) begin
            b = unit_bytes.pop_back();
            b.run_last   = 1'b1;
            b.string_end = last;
            add_unit_byte(b);
        end
        foreach (unit_bytes[k]) begin
            awaited_bytes.insert(awaited_bytes.size(), unit_bytes[k]);
        end
    endtask

    // Predict on every input transfer and compare on every output transfer.
    always @(posedge i_clk) begin
        utf8_out_t got;
        utf8_out_t want;
        if (!i_rst_n) begin
            held_bits  = '0;
            held_valid = 1'b0;
            awaited_bytes.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_unit(i_code_unit, i_string_last);
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_utf8_byte, i_run_last, i_string_end};
                if (awaited_bytes.size() == 0) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("unexpected transfer: byte %02h run_last %0b string_end %0b",
                                 got.octet, got.run_last, got.string_end);
                    end
                    fail_count = fail_count + 1;
                end else begin
                    want = awaited_bytes.pop_front();
                    if (got !== want) begin
                        if (fail_count < REPORT_LIMIT) begin
                            $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     want.octet, want.run_last, want.string_end,
                                     got.octet, got.run_last, got.string_end);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        o_bytes_pending <= awaited_bytes.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the transcoder testbench: clock, reset, stimulus, output stalls and the verdict.
module testbench;

    localparam int UNIT_TARGET  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PERCENT = 8;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [15:0] i_code_unit   = '0;
    logic        i_string_last = 1'b0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_utf8_byte;
    logic        o_run_last;
    logic        o_string_end;
    int          fail_count;
    int          bytes_pending;
    int          cycle_count   = 0;
    int          units_sent    = 0;
    logic        no_idling     = 1'b0;

    utf16_to_utf8_transcoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_code_unit   (i_code_unit),
        .i_string_last (i_string_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_utf8_byte   (o_utf8_byte),
        .o_run_last    (o_run_last),
        .o_string_end  (o_string_end)
    );

    utf8_stream_checker stream_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_code_unit     (i_code_unit),
        .i_string_last   (i_string_last),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_utf8_byte     (o_utf8_byte),
        .i_run_last      (o_run_last),
        .i_string_end    (o_string_end),
        .o_fail_count    (fail_count),
        .o_bytes_pending (bytes_pending)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls now and then, except in the quiet stretch.
    always @(posedge i_clk) begin
        i_out_ready <= no_idling || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offers one code unit, with an occasional gap first, and waits for its transfer.
    task automatic send_unit(input logic [15:0] unit, input logic last);
        while (!no_idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_code_unit   <= unit;
        i_string_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
        units_sent = units_sent + 1;
    endtask

    // Sends one string of mostly well-formed characters; some end without a last flag.
    task automatic send_random_string();
        int   len;
        int   kind;
        logic last;
        logic ends;
        len  = $urandom_range(1, 6);
        ends = $urandom_range(0, 9) != 0;
        for (int k = 0; k < len; k++) begin
            last = ends && (k == len - 1);
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                send_unit(16'($urandom_range(16'h0000, 16'h007F)), last);
            end else if (kind < 45) begin
                send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
            end else if (kind < 55) begin
                send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), last);
            end else if (kind < 65) begin
                send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last);
            end else if (kind < 88) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
            end else if (kind < 92) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), last);
            end else if (kind < 96) begin
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
            end else begin
                send_unit(16'($urandom()), $urandom_range(0, 1) == 1);
            end
        end
    endtask

    // Reset, directed cases, random strings, drain and verdict.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Length boundaries of the encoding.
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Lowest and highest surrogate pairs.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Unpaired low surrogate at the end of a string.
        send_unit(16'hDC00, 1'b1);
        // Held surrogate followed by an ordinary unit.
        send_unit(16'hD900, 1'b0);
        send_unit(16'h0041, 1'b0);
        // Held surrogate replaced by another high surrogate, which then pairs.
        send_unit(16'hDA00, 1'b0);
        send_unit(16'hDB00, 1'b0);
        send_unit(16'hDC12, 1'b1);
        // High surrogate that ends the string goes out at once.
        send_unit(16'hD812, 1'b1);
        // Held surrogate flushed before the last unit of the string.
        send_unit(16'hDABC, 1'b0);
        send_unit(16'h20AC, 1'b1);
        // Held surrogate pairs with a low surrogate that ends the string.
        send_unit(16'hDBC0, 1'b0);
        send_unit(16'hDE01, 1'b1);
        // Two high surrogates, the second closing the string.
        send_unit(16'hD955, 1'b0);
        send_unit(16'hDAAA, 1'b1);

        // Random strings, with a stretch in the middle where neither side idles.
        while (units_sent < UNIT_TARGET) begin
            no_idling = (units_sent >= 50) && (units_sent < 95);
            send_random_string();
        end
        no_idling = 1'b0;
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (bytes_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && bytes_pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
